// ----- hw/rtl/bmm_pkg.sv -----
// Shared types and constants for the batched matrix multiply unit.
`default_nettype none

package bmm_pkg;

  localparam int unsigned MaxDimDefault = 8;

  localparam int unsigned ElemW    = 16;
  localparam int unsigned ProdW    = 2 * ElemW;
  localparam int unsigned AccW     = 40;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COLS_B    = 2'd2;

  localparam logic OP_LOAD_A = 1'b0;
  localparam logic OP_LOAD_B = 1'b1;

  typedef struct packed {
    logic                    op;
    logic signed [ElemW-1:0] element_value;
  } bmm_in_t;

  typedef struct packed {
    logic signed [AccW-1:0] product_value;
    logic                   last_of_batch;
  } bmm_out_t;

  // Control that travels with each product term down the pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last_dot;
    logic last_batch;
  } bmm_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmm_mac.sv -----
// Multiply-accumulate datapath: registered product, then running dot-product sum.
`default_nettype none

module bmm_mac (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire bmm_pkg::bmm_ctl_t                ctl_i,
  input  wire logic signed [bmm_pkg::ElemW-1:0] a_i,
  input  wire logic signed [bmm_pkg::ElemW-1:0] b_i,
  output bmm_pkg::bmm_ctl_t                     ctl_o,
  output logic signed [bmm_pkg::AccW-1:0]       sum_o
);
  import bmm_pkg::*;

  logic signed [ProdW-1:0] prod_q;
  bmm_ctl_t                ctl_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  // Restart the sum on the first term of each dot product.
  always_comb begin
    sum_d = (ctl_q.first ? '0 : acc_q) + AccW'(prod_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctl_q.valid) begin
      acc_q <= sum_d;
    end
  end

  assign ctl_o = ctl_q;
  assign sum_o = sum_d;

endmodule

`default_nettype wire

// ----- hw/rtl/batched_matrix_multiply_unit.sv -----
// Top level of the batched matrix multiply unit: stores, sequencer and output register.
// Loading: one transaction per cycle while in the load state; each element is written to store A or B at once.
// Emission: the transaction that fills both stores starts a pass through the single
// multiply-accumulate unit, one store read per cycle while the output is not stalled;
// each result goes from the read and product registers through the running sum to the output register.
// Reset: element counts clear, dimension registers return to 8, stores are not cleared.
`default_nettype none

module batched_matrix_multiply_unit #(
  parameter int unsigned MAX_DIM = bmm_pkg::MaxDimDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [bmm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bmm_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire bmm_pkg::bmm_in_t             in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output bmm_pkg::bmm_out_t                 out_data_o
);
  import bmm_pkg::*;

  localparam int unsigned Depth  = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned IdxW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DimW   = $clog2(MAX_DIM + 1);

  localparam logic S_LOAD = 1'b0;
  localparam logic S_CALC = 1'b1;

  // Dimension registers, clamped into 1..MAX_DIM where they are used.
  logic [CfgDataW-1:0] rows_a_q, inner_len_q, cols_b_q;

  function automatic logic [DimW-1:0] clamp_dim(input logic [CfgDataW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > CfgDataW'(MAX_DIM)) begin
      r = DimW'(MAX_DIM);
    end else begin
      r = DimW'(v);
    end
    return r;
  endfunction

  logic [DimW-1:0] dim_m, dim_k, dim_n;
  logic [CntW-1:0] size_a, size_b;

  assign dim_m  = clamp_dim(rows_a_q);
  assign dim_k  = clamp_dim(inner_len_q);
  assign dim_n  = clamp_dim(cols_b_q);
  assign size_a = CntW'(dim_m) * CntW'(dim_k);
  assign size_b = CntW'(dim_k) * CntW'(dim_n);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= CfgDataW'(8);
      inner_len_q <= CfgDataW'(8);
      cols_b_q    <= CfgDataW'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        CFG_INNER_LEN: inner_len_q <= cfg_data_i;
        CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Load side. Elements are taken only in the load state; an element for a
  // store that already holds its configured size is dropped.
  // ---------------------------------------------------------------------------
  logic            state_q, state_d;
  logic [CntW-1:0] count_a_q, count_a_d;
  logic [CntW-1:0] count_b_q, count_b_d;
  logic            in_acc, wr_a, wr_b, batch_full;
  logic [CntW-1:0] count_a_nx, count_b_nx;

  assign in_ready_o = (state_q == S_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_a       = in_acc && (in_data_i.op == OP_LOAD_A) && (count_a_q < size_a);
  assign wr_b       = in_acc && (in_data_i.op == OP_LOAD_B) && (count_b_q < size_b);
  assign count_a_nx = count_a_q + CntW'(wr_a);
  assign count_b_nx = count_b_q + CntW'(wr_b);
  // Check with the sizes in force now, so a shrink makes the next item emit.
  assign batch_full = in_acc && (count_a_nx >= size_a) && (count_b_nx >= size_b);

  // ---------------------------------------------------------------------------
  // Issue sequencer: walks i, j, t and keeps both store addresses
  // incrementally (a = i*k + t, b = t*n + j).
  // ---------------------------------------------------------------------------
  logic             adv;
  logic [IdxW-1:0]  t_q, j_q, i_q;
  logic [AddrW-1:0] addr_a_q, addr_b_q, row_base_q;
  logic             last_t, last_j, last_i;
  bmm_ctl_t         issue_ctl;

  assign last_t = (DimW'(t_q) + DimW'(1)) == dim_k;
  assign last_j = (DimW'(j_q) + DimW'(1)) == dim_n;
  assign last_i = (DimW'(i_q) + DimW'(1)) == dim_m;

  assign issue_ctl.valid      = (state_q == S_CALC);
  assign issue_ctl.first      = (t_q == '0);
  assign issue_ctl.last_dot   = last_t;
  assign issue_ctl.last_batch = last_t && last_j && last_i;

  always_comb begin
    state_d   = state_q;
    count_a_d = count_a_nx;
    count_b_d = count_b_nx;
    if (batch_full) begin
      state_d   = S_CALC;
      count_a_d = '0;
      count_b_d = '0;
    end
    if (state_q == S_CALC && adv && issue_ctl.last_batch) begin
      state_d = S_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_a_q <= '0;
      count_b_q <= '0;
    end else begin
      state_q   <= state_d;
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q        <= '0;
      j_q        <= '0;
      i_q        <= '0;
      addr_a_q   <= '0;
      addr_b_q   <= '0;
      row_base_q <= '0;
    end else if (state_q == S_CALC && adv) begin
      if (!last_t) begin
        t_q      <= t_q + IdxW'(1);
        addr_a_q <= addr_a_q + AddrW'(1);
        addr_b_q <= addr_b_q + AddrW'(dim_n);
      end else begin
        t_q <= '0;
        if (!last_j) begin
          j_q      <= j_q + IdxW'(1);
          addr_a_q <= row_base_q;
          addr_b_q <= AddrW'(j_q) + AddrW'(1);
        end else begin
          j_q      <= '0;
          addr_b_q <= '0;
          if (!last_i) begin
            i_q        <= i_q + IdxW'(1);
            row_base_q <= row_base_q + AddrW'(dim_k);
            addr_a_q   <= row_base_q + AddrW'(dim_k);
          end else begin
            // Batch fully issued: return to origin for the next one.
            i_q        <= '0;
            row_base_q <= '0;
            addr_a_q   <= '0;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Element stores: one write port from the load side, one registered read
  // port from the sequencer. Loads and reads never overlap in time, since
  // reads happen only in the calc state and writes only in the load state.
  // ---------------------------------------------------------------------------
  logic signed [ElemW-1:0] mem_a [Depth];
  logic signed [ElemW-1:0] mem_b [Depth];
  logic signed [ElemW-1:0] rd_a_q, rd_b_q;
  bmm_ctl_t                ctl1_q;
  logic                    issue_rd;

  assign issue_rd = adv && issue_ctl.valid;

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[count_a_q[AddrW-1:0]] <= in_data_i.element_value;
    end
    if (issue_rd) begin
      rd_a_q <= mem_a[addr_a_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[count_b_q[AddrW-1:0]] <= in_data_i.element_value;
    end
    if (issue_rd) begin
      rd_b_q <= mem_b[addr_b_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (adv) begin
      ctl1_q <= issue_ctl;
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply-accumulate and output register. The whole read/MAC pipeline
  // holds while a finished result waits and the consumer stalls.
  // ---------------------------------------------------------------------------
  bmm_ctl_t               ctl2;
  logic signed [AccW-1:0] mac_sum;
  logic                   out_valid_q;
  bmm_out_t               out_data_q;

  assign adv = !out_valid_q || out_ready_i;

  bmm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (ctl1_q),
    .a_i    (rd_a_q),
    .b_i    (rd_b_q),
    .ctl_o  (ctl2),
    .sum_o  (mac_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctl2.valid && ctl2.last_dot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && ctl2.valid && ctl2.last_dot) begin
      out_data_q.product_value <= mac_sum;
      out_data_q.last_of_batch <= ctl2.last_batch;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // Element counts never pass the store depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_a_q <= CntW'(Depth)) && (count_b_q <= CntW'(Depth)))
    else $error("element count beyond store depth");

  // Issued addresses stay inside the loaded part of each store.
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |-> (CntW'(addr_a_q) < size_a) && (CntW'(addr_b_q) < size_b))
    else $error("store read beyond loaded elements");

  // A transaction that fills both stores starts emission with counts cleared.
  a_fill_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    batch_full |=> (state_q == S_CALC) && (count_a_q == '0) && (count_b_q == '0))
    else $error("full batch did not start emission");

  // No store write while the sequencer is reading.
  a_no_write_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |-> !wr_a && !wr_b)
    else $error("store written during emission");
`endif

endmodule

`default_nettype wire
